// ===== hw/rtl/gkc_pkg.sv =====
// Shared types, constants and constant functions of the Gabor kernel coefficient generator.
`timescale 1ns / 1ps

package gkc_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HALF_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_COS_ANGLE    = 3'd2;
    localparam logic [2:0] REG_SIN_ANGLE    = 3'd3;
    localparam logic [2:0] REG_GAIN_X       = 3'd4;
    localparam logic [2:0] REG_GAIN_Y       = 3'd5;
    localparam logic [2:0] REG_WAVE_RATE    = 3'd6;
    localparam logic [2:0] REG_PHASE_OFFSET = 3'd7;

    // log2(e) in Q.16.
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // Even polynomial for the cosine over one quadrant, Horner order.
    localparam int COS_P0 = 1731866;
    localparam int COS_NPOLY = 5;
    localparam int COS_K [COS_NPOLY] = '{3948193, 5600498, 4255868, 1293629, 65536};

    // Number of fraction bits of the exponent, one factor stage per bit.
    localparam int EXP_FRAC_BITS = 16;

    typedef struct packed {
        logic [3:0]         half_width;
        logic [3:0]         half_height;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [23:0]        gain_x;
        logic [23:0]        gain_y;
        logic [15:0]        wave_rate;
        logic [15:0]        phase_offset;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        half_width:   4'd1,
        half_height:  4'd1,
        cos_angle:    16'sd16384,
        sin_angle:    16'sd0,
        gain_x:       24'd32768,
        gain_y:       24'd32768,
        wave_rate:    16'd16384,
        phase_offset: 16'd0
    };

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic               oor;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [21:0] xr;
        logic signed [21:0] yr;
        logic [25:0]        sqx;
        logic [25:0]        sqy;
        logic [15:0]        ph;
        logic [19:0]        e;
        logic               big;
        logic signed [15:0] cosv;
        logic [3:0]         n;
        logic               zero;
        logic [15:0]        f;
        logic [30:0]        g;
    } t_item;

    // Floor integer square root, used only to build constants.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = 64'd0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Q2.30 factor 2^(-2^-(k+1)) as a chain of square roots from one half.
    function automatic logic [63:0] exp_root(input int k);
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int j = 1; j <= k; j++) begin
            r = isqrt64(r << 30);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/gabor_kernel_coefficient.sv =====
// Top level of the Gabor kernel coefficient generator: registers, pipeline and output stage.
//
//  Channel   Direction  Carries
//  s_axis    in         tdata: x_offset[4:0], y_offset[9:5]
//  m_axis    out        tdata: coefficient[15:0], row_index[20:16], col_index[25:21];
//                       tuser: out_of_range[0]
//  APB       in/out     eight configuration registers at byte addresses 0 to 28
//
// One transaction can be taken every clock while no result waits at the output; the
// pipeline has 3 front, 7 cosine, 18 envelope and 1 output stage, the envelope
// depth set by its sixteen root-factor multiplies. All stages advance together and
// hold while a finished result waits at the output. Reset clears the valid
// bits and loads the register defaults; nothing needs clearing beyond that.
`timescale 1ns / 1ps

module gabor_kernel_coefficient import gkc_pkg::*; #(
    parameter int MAX_HALF_SIZE  = 15,
    parameter int COS_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // x_offset[4:0], y_offset[9:5], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // coefficient[15:0], row_index[20:16],
                                        // col_index[25:21], zero fill
    output logic [0:0]  m_axis_tuser,   // out_of_range[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    logic w_wr;
    logic w_adv;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_HALF_WIDTH:   r_cfg.half_width   <= pwdata[3:0];
                REG_HALF_HEIGHT:  r_cfg.half_height  <= pwdata[3:0];
                REG_COS_ANGLE:    r_cfg.cos_angle    <= pwdata[15:0];
                REG_SIN_ANGLE:    r_cfg.sin_angle    <= pwdata[15:0];
                REG_GAIN_X:       r_cfg.gain_x       <= pwdata[23:0];
                REG_GAIN_Y:       r_cfg.gain_y       <= pwdata[23:0];
                REG_WAVE_RATE:    r_cfg.wave_rate    <= pwdata[15:0];
                REG_PHASE_OFFSET: r_cfg.phase_offset <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            REG_HALF_WIDTH:   prdata = {28'd0, r_cfg.half_width};
            REG_HALF_HEIGHT:  prdata = {28'd0, r_cfg.half_height};
            REG_COS_ANGLE:    prdata = {16'd0, r_cfg.cos_angle};
            REG_SIN_ANGLE:    prdata = {16'd0, r_cfg.sin_angle};
            REG_GAIN_X:       prdata = {8'd0, r_cfg.gain_x};
            REG_GAIN_Y:       prdata = {8'd0, r_cfg.gain_y};
            REG_WAVE_RATE:    prdata = {16'd0, r_cfg.wave_rate};
            REG_PHASE_OFFSET: prdata = {16'd0, r_cfg.phase_offset};
            default:          prdata = 32'd0;
        endcase
    end

    // The whole pipeline moves unless a result is waiting to be taken.
    assign w_adv         = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = w_adv;

    logic  w_f_vld, w_c_vld, w_e_vld;
    t_item w_f_it, w_c_it, w_e_it;

    gkc_front #(
        .MAX_HALF_SIZE (MAX_HALF_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (s_axis_tvalid),
        .i_x     ($signed(s_axis_tdata[4:0])),
        .i_y     ($signed(s_axis_tdata[9:5])),
        .i_cfg   (r_cfg),
        .o_valid (w_f_vld),
        .o_item  (w_f_it)
    );

    gkc_cosine #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_cosine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_f_vld),
        .i_item  (w_f_it),
        .o_valid (w_c_vld),
        .o_item  (w_c_it)
    );

    gkc_envelope u_envelope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_c_vld),
        .i_item  (w_c_it),
        .o_valid (w_e_vld),
        .o_item  (w_e_it)
    );

    // Final product of envelope and cosine, rounded half up and saturated.
    logic signed [47:0] w_prod;
    logic signed [47:0] w_sh;
    logic signed [15:0] n_coef;

    always_comb begin
        w_prod = 48'($signed({1'b0, w_e_it.g})) * 48'(w_e_it.cosv);
        w_sh   = (w_prod + 48'sd268435456) >>> 29;
        if (w_e_it.oor) begin
            n_coef = 16'sd0;
        end else if (w_sh > 48'sd32767) begin
            n_coef = 16'sd32767;
        end else if (w_sh < -48'sd32768) begin
            n_coef = -16'sd32768;
        end else begin
            n_coef = 16'(w_sh);
        end
    end

    logic               r_out_vld;
    logic signed [15:0] r_coef;
    logic [4:0]         r_row;
    logic [4:0]         r_col;
    logic               r_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_coef <= n_coef;
            r_row  <= w_e_it.row;
            r_col  <= w_e_it.col;
            r_oor  <= w_e_it.oor;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_col, r_row, r_coef};
    assign m_axis_tuser  = r_oor;

    // An offset outside the kernel carries a zero value and zero position.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_oor) |-> (r_coef == 16'sd0 && r_row == 5'd0 && r_col == 5'd0))
        else $error("out-of-range result with non-zero fields");

    // A position inside the kernel stays within twice the half height.
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_oor) |-> ({1'b0, r_row} <= {1'b0, r_cfg.half_height, 1'b0}))
        else $error("row index beyond kernel height");

    // No result appears in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_vld)
        else $error("result valid straight after reset");

endmodule

// ===== hw/rtl/gkc_front.sv =====
// Front stages: range check, rotation, squares, phase and exponent.
`timescale 1ns / 1ps

module gkc_front import gkc_pkg::*; #(
    parameter int MAX_HALF_SIZE = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic signed [4:0] i_x,
    input  logic signed [4:0] i_y,
    input  t_cfg              i_cfg,
    output logic              o_valid,
    output t_item             o_item
);

    localparam logic [6:0] MAX7 = 7'(MAX_HALF_SIZE);

    logic [2:0] r_vld;
    t_item      r_s1, r_s2, r_s3;
    t_item      n_s1, n_s2, n_s3;

    logic [6:0]         w_hw, w_hh, w_ax, w_ay;
    logic               w_oor;
    logic signed [43:0] w_sqx, w_sqy;
    logic [29:0]        w_xr_u;
    logic [45:0]        w_php;
    logic [49:0]        w_gx, w_gy;
    logic [50:0]        w_es;

    // Stage one: bounds against the capped half sizes and the rotation.
    always_comb begin
        w_hw = ({3'b000, i_cfg.half_width} > MAX7) ? MAX7 : {3'b000, i_cfg.half_width};
        w_hh = ({3'b000, i_cfg.half_height} > MAX7) ? MAX7 : {3'b000, i_cfg.half_height};
        w_ax = i_x[4] ? 7'(-(7'(i_x))) : 7'(i_x);
        w_ay = i_y[4] ? 7'(-(7'(i_y))) : 7'(i_y);
        w_oor = (w_ax > w_hw) || (w_ay > w_hh);
        n_s1 = '0;
        n_s1.oor = w_oor;
        n_s1.row = w_oor ? 5'd0 : 5'(w_hh[4:0] - $unsigned(i_y));
        n_s1.col = w_oor ? 5'd0 : 5'(w_hw[4:0] - $unsigned(i_x));
        n_s1.xr  = 22'(i_x) * 22'(i_cfg.cos_angle) + 22'(i_y) * 22'(i_cfg.sin_angle);
        n_s1.yr  = 22'(i_y) * 22'(i_cfg.cos_angle) - 22'(i_x) * 22'(i_cfg.sin_angle);
    end

    // Stage two: squares cut to Q.14 and the phase in turns.
    always_comb begin
        w_sqx  = 44'(r_s1.xr) * 44'(r_s1.xr);
        w_sqy  = 44'(r_s1.yr) * 44'(r_s1.yr);
        w_xr_u = 30'($unsigned(30'(r_s1.xr)));
        w_php  = 46'(i_cfg.wave_rate) * 46'(w_xr_u);
        n_s2 = r_s1;
        n_s2.sqx = w_sqx[39:14];
        n_s2.sqy = w_sqy[39:14];
        n_s2.ph  = w_php[29:14] + i_cfg.phase_offset;
    end

    // Stage three: weighted sum of squares gives the exponent in Q.16.
    always_comb begin
        w_gx = 50'(i_cfg.gain_x) * 50'(r_s2.sqx);
        w_gy = 50'(i_cfg.gain_y) * 50'(r_s2.sqy);
        w_es = {1'b0, w_gx} + {1'b0, w_gy};
        n_s3 = r_s2;
        n_s3.e   = w_es[33:14];
        n_s3.big = |w_es[50:34];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'b000;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_vld[2];
    assign o_item  = r_s3;

endmodule

// ===== hw/rtl/gkc_cosine.sv =====
// Cosine stages: quadrant fold, polynomial in Horner steps, rounding and sign.
`timescale 1ns / 1ps

module gkc_cosine import gkc_pkg::*; #(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam int          NC      = COS_NPOLY + 2;
    localparam logic [15:0] PH_MASK = 16'hFFFF << (16 - COS_TABLE_BITS);

    logic               r_vld [NC];
    t_item              r_it  [NC];
    logic signed [31:0] r_p   [NC];
    logic [26:0]        r_w   [NC];
    logic               r_neg [NC];

    logic [15:0] w_t;
    logic [14:0] w_u;
    logic [29:0] w_uu;

    // Fold the phase into the first quadrant and square it.
    always_comb begin
        w_t  = i_item.ph & PH_MASK;
        w_u  = w_t[14] ? 15'(15'd16384 - {1'b0, w_t[13:0]}) : {1'b0, w_t[13:0]};
        w_uu = 30'(w_u) * 30'(w_u);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0]  <= i_item;
            r_w[0]   <= w_uu[28:2];
            r_p[0]   <= 32'(COS_P0);
            r_neg[0] <= w_t[15] ^ w_t[14];
        end
    end

    // One Horner step per stage.
    for (genvar k = 1; k <= COS_NPOLY; k++) begin : g_poly
        logic signed [59:0] w_prod;
        logic signed [59:0] w_shr;
        assign w_prod = 60'(r_p[k-1]) * 60'($signed({1'b0, r_w[k-1]}));
        assign w_shr  = w_prod >>> 30;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_it[k]  <= r_it[k-1];
                r_w[k]   <= r_w[k-1];
                r_neg[k] <= r_neg[k-1];
                r_p[k]   <= 32'(COS_K[k-1]) - 32'(w_shr);
            end
        end
    end

    logic signed [31:0] w_pr;
    logic signed [15:0] w_cl;
    t_item              n_last;

    // Round to Q1.14, clamp to the unit range and apply the quadrant sign.
    always_comb begin
        w_pr = (r_p[NC-2] + 32'sd2) >>> 2;
        if (w_pr < 32'sd0) begin
            w_cl = 16'sd0;
        end else if (w_pr > 32'sd16384) begin
            w_cl = 16'sd16384;
        end else begin
            w_cl = 16'(w_pr);
        end
        n_last = r_it[NC-2];
        n_last.cosv = r_neg[NC-2] ? 16'(-w_cl) : w_cl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[NC-1] <= 1'b0;
        end else if (i_en) begin
            r_vld[NC-1] <= r_vld[NC-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[NC-1]  <= n_last;
            r_w[NC-1]   <= r_w[NC-2];
            r_p[NC-1]   <= r_p[NC-2];
            r_neg[NC-1] <= r_neg[NC-2];
        end
    end

    assign o_valid = r_vld[NC-1];
    assign o_item  = r_it[NC-1];

endmodule

// ===== hw/rtl/gkc_envelope.sv =====
// Envelope stages: base-two exponent split, one root factor per stage, final shift.
`timescale 1ns / 1ps

module gkc_envelope import gkc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam int NE = EXP_FRAC_BITS + 2;

    logic  r_vld [NE];
    t_item r_it  [NE];

    logic [36:0] w_tp;
    t_item       n_first;

    // Scale by log2(e) and split into whole and fractional octaves.
    always_comb begin
        w_tp    = 37'(i_item.e) * 37'(LOG2E_Q16);
        n_first = i_item;
        n_first.n    = w_tp[35:32];
        n_first.zero = i_item.big | w_tp[36];
        n_first.f    = w_tp[31:16];
        n_first.g    = 31'(32'd1 << 30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0] <= n_first;
        end
    end

    // Multiply in the factor for each set fraction bit, top bit first.
    for (genvar k = 0; k < EXP_FRAC_BITS; k++) begin : g_fact
        localparam logic [29:0] ROOT = 30'(exp_root(k));
        logic [60:0] w_prod;
        t_item       n_it;
        assign w_prod = 61'(r_it[k].g) * 61'(ROOT);

        always_comb begin
            n_it = r_it[k];
            if (r_it[k].f[EXP_FRAC_BITS-1-k]) begin
                n_it.g = w_prod[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_it[k+1] <= n_it;
            end
        end
    end

    t_item n_last;

    // Whole octaves as a right shift; a large exponent gives zero.
    always_comb begin
        n_last = r_it[NE-2];
        n_last.g = r_it[NE-2].zero ? 31'd0 : (r_it[NE-2].g >> r_it[NE-2].n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[NE-1] <= 1'b0;
        end else if (i_en) begin
            r_vld[NE-1] <= r_vld[NE-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[NE-1] <= n_last;
        end
    end

    assign o_valid = r_vld[NE-1];
    assign o_item  = r_it[NE-1];

endmodule

// ===== bench/gabor_kernel_coefficient_tb.sv =====
// Self-checking bench for the Gabor kernel coefficient generator.
`timescale 1ns / 1ps

module gabor_kernel_coefficient_tb;
    import gkc_pkg::*;

    localparam int HALF_MAX   = 15;
    localparam int PHASE_BITS = 10;
    localparam int LATENCY    = 29;
    localparam int WATCHDOG   = 20000;

    typedef struct {
        logic signed [15:0] coefficient;
        logic [4:0]         row_index;
        logic [4:0]         col_index;
        logic               out_of_range;
    } t_coef;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Bench copy of the configuration.
    logic [3:0]         hw_r = 4'd1;
    logic [3:0]         hh_r = 4'd1;
    logic signed [15:0] cos_r = 16'sd16384;
    logic signed [15:0] sin_r = 16'sd0;
    logic [23:0]        gx_r = 24'd32768;
    logic [23:0]        gy_r = 24'd32768;
    logic [15:0]        rate_r = 16'd16384;
    logic [15:0]        phase_r = 16'd0;

    logic [9:0] offset_q[$];
    t_coef      coef_q[$];
    int         errors = 0;
    int         idle_cycles = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    bit         timed_out = 1'b0;

    gabor_kernel_coefficient DUT (.*);

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // 2^-f in Q2.30 for a Q0.16 fraction.
    function automatic longint unsigned envelope_frac(longint unsigned f);
        longint unsigned g, root;
        g = 64'd1 << 30;
        root = int_sqrt(64'd1 << 59);
        for (int k = 0; k < 16; k++) begin
            if (k > 0) root = int_sqrt(root << 30);
            if ((f >> (15 - k)) & 1) g = (g * root) >> 30;
        end
        return g;
    endfunction

    function automatic longint quarter_cos(longint unsigned u);
        longint w, p;
        w = longint'((u * u) >> 2);
        p = 1731866;
        p = 3948193 - fl_shift(p * w, 30);
        p = 5600498 - fl_shift(p * w, 30);
        p = 4255868 - fl_shift(p * w, 30);
        p = 1293629 - fl_shift(p * w, 30);
        p = 65536 - fl_shift(p * w, 30);
        p = fl_shift(p + 2, 2);
        if (p < 0) p = 0;
        if (p > 16384) p = 16384;
        return p;
    endfunction

    function automatic longint phase_cos(logic [15:0] t);
        logic [1:0]  q;
        longint unsigned r;
        t = t & ~((16'd1 << (16 - PHASE_BITS)) - 16'd1);
        q = t[15:14];
        r = t[13:0];
        case (q)
            2'd0: return quarter_cos(r);
            2'd1: return -quarter_cos(16384 - r);
            2'd2: return -quarter_cos(r);
            default: return quarter_cos(16384 - r);
        endcase
    endfunction

    function automatic t_coef gabor_value(logic signed [4:0] xo, logic signed [4:0] yo);
        t_coef res;
        longint x, y, hw, hh, xr, yr, cv, prod;
        longint unsigned e, t, n, env, ph;
        x = xo;
        y = yo;
        hw = (hw_r > HALF_MAX) ? HALF_MAX : hw_r;
        hh = (hh_r > HALF_MAX) ? HALF_MAX : hh_r;
        res = '{16'sd0, 5'd0, 5'd0, 1'b1};
        if (x > hw || -x > hw || y > hh || -y > hh) return res;
        xr = x * cos_r + y * sin_r;
        yr = -x * sin_r + y * cos_r;
        e = (longint'(gx_r) * (longint'(xr * xr) >>> 14)
             + longint'(gy_r) * (longint'(yr * yr) >>> 14)) >> 14;
        t = (e * 94548) >> 16;
        n = t >> 16;
        env = (n >= 16) ? 0 : (envelope_frac(t & 16'hFFFF) >> n);
        ph = ((longint'(rate_r) * xr) >>> 14) + phase_r;
        cv = phase_cos(ph[15:0]);
        prod = fl_shift(longint'(env) * cv + (64'sd1 <<< 28), 29);
        if (prod > 32767) prod = 32767;
        if (prod < -32768) prod = -32768;
        res.coefficient = prod[15:0];
        res.row_index = 5'(hh - y);
        res.col_index = 5'(hw - x);
        res.out_of_range = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Register write over APB: setup then access cycle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_HALF_WIDTH:   hw_r = val[3:0];
            REG_HALF_HEIGHT:  hh_r = val[3:0];
            REG_COS_ANGLE:    cos_r = val[15:0];
            REG_SIN_ANGLE:    sin_r = val[15:0];
            REG_GAIN_X:       gx_r = val[23:0];
            REG_GAIN_Y:       gy_r = val[23:0];
            REG_WAVE_RATE:    rate_r = val[15:0];
            default:          phase_r = val[15:0];
        endcase
    endtask

    task automatic wait_idle();
        while (offset_q.size() != 0 || coef_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Driver: one offset transaction at a time from the pending queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                coef_q.push_back(gabor_value(s_axis_tdata[4:0], s_axis_tdata[9:5]));
                void'(offset_q.pop_front());
                send_gap = pick_gap();
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (offset_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, offset_q[0]};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction and randomise back-pressure.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (coef_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 0);
                end else begin
                    t_coef w;
                    w = coef_q.pop_front();
                    if (m_axis_tdata[15:0] !== w.coefficient)
                        report_mismatch("coefficient", $signed(m_axis_tdata[15:0]),
                                        w.coefficient);
                    if (m_axis_tdata[20:16] !== w.row_index)
                        report_mismatch("row_index", m_axis_tdata[20:16], w.row_index);
                    if (m_axis_tdata[25:21] !== w.col_index)
                        report_mismatch("col_index", m_axis_tdata[25:21], w.col_index);
                    if (m_axis_tuser[0] !== w.out_of_range)
                        report_mismatch("out_of_range", m_axis_tuser[0], w.out_of_range);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles without any accepted transaction while work is pending.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || offset_q.size() + coef_q.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_offset(int x, int y);
        offset_q.push_back({5'(y), 5'(x)});
    endtask

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                offset_q.push_back(10'($urandom));
            else
                push_offset($urandom_range(0, 2 * hw_r) - hw_r,
                            $urandom_range(0, 2 * hh_r) - hh_r);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, corners and out-of-range offsets.
        push_offset(0, 0);  push_offset(1, 1);  push_offset(-1, -1);
        push_offset(2, 0);  push_offset(0, -2); push_offset(-16, 15);
        push_offset(15, -16);
        wait_idle();
        write_reg(REG_HALF_WIDTH, 32'hF);
        write_reg(REG_HALF_HEIGHT, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_X, 32'd0);
        write_reg(REG_GAIN_Y, 32'd0);
        write_reg(REG_WAVE_RATE, 32'd0);
        push_offset(0, 0);  push_offset(15, 15); push_offset(-15, -15);
        push_offset(-16, 0); push_offset(0, -16); push_offset(15, -15);
        wait_idle();
        write_reg(REG_GAIN_X, 32'hFF_FFFF);
        write_reg(REG_GAIN_Y, 32'hFF_FFFF);
        write_reg(REG_COS_ANGLE, 32'hFFFF_C000);
        write_reg(REG_SIN_ANGLE, 32'h4000);
        write_reg(REG_WAVE_RATE, 32'hFFFF);
        write_reg(REG_PHASE_OFFSET, 32'hFFFF);
        push_offset(0, 0); push_offset(1, 0); push_offset(-15, 15);
        push_offset(7, -3);
        wait_idle();

        // Random phases over a range of settings.
        for (int p = 0; p < 16; p++) begin
            write_reg(REG_HALF_WIDTH, $urandom);
            write_reg(REG_HALF_HEIGHT, $urandom);
            write_reg(REG_COS_ANGLE, (p % 4 == 0) ? 32'hC000 : $urandom_range(0, 32768) - 16384);
            write_reg(REG_SIN_ANGLE, $urandom_range(0, 32768) - 16384);
            write_reg(REG_GAIN_X, (p % 3 == 0) ? $urandom : $urandom_range(0, 16'hFFFF));
            write_reg(REG_GAIN_Y, (p % 3 == 1) ? $urandom : $urandom_range(0, 16'h3FFF));
            write_reg(REG_WAVE_RATE, $urandom);
            write_reg(REG_PHASE_OFFSET, $urandom);
            random_burst(50);
            wait_idle();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
